/* hw/rtl/mmt_pkg.sv */
// Shared constants, types and controller/datapath interface structs of the tracker.
`timescale 1ns / 1ps

package mmt_pkg;

    localparam int MAX_SAMPLES = 65535;

    localparam int TEMP_W  = 14;
    localparam int PRESS_W = 11;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int TSUM_W  = TEMP_W + CNT_W;
    localparam int PSUM_W  = PRESS_W + CNT_W;

    // Shared divider: dividend is the widest sum magnitude, quotient fits the temperature width.
    localparam int DVD_W   = TSUM_W;
    localparam int QUO_W   = TEMP_W;
    localparam int STEP_W  = $clog2(QUO_W + 1);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam logic DIV_SEL_PRESS = 1'b0;
    localparam logic DIV_SEL_TEMP  = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_PGO    = 7'b0000100,
        S_PWAIT  = 7'b0001000,
        S_TGO    = 7'b0010000,
        S_TWAIT  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic div_start;
        logic div_sel;
        logic mean_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

/* hw/rtl/dual_channel_min_max_mean_tracker_unit.sv */
// Top level of the dual-channel running min/max/mean tracker.
`timescale 1ns / 1ps

// Running statistics for a temperature channel (signed centidegrees) and a
// pressure channel (unsigned hPa). Each input transfer is either a sample
// (req_type 0) or a read (req_type 1), and each gives exactly one result
// transfer. A sample is taken only if its pressure is nonzero; accepted reports
// this, and all other result fields of a sample are zero. A taken sample
// becomes the current value and updates min and max; while the count is below
// MAX_SAMPLES it also adds to the sums and both means are recomputed as
// sum / count, truncated toward zero. The first sample after a clear seeds min,
// max, mean and sum. A read returns current, min, max and mean of both
// channels, then clears count and sums (min, max, mean and current stay).
// A sample that recomputes the means occupies the block from its input transfer
// until the next one can be taken, set by one shared restoring divider that
// produces one quotient bit per cycle (14 steps) and runs once for pressure and
// once for temperature. Reads, rejected samples, seeding samples and samples at
// the count limit skip the divider. The result sits in an output register, so a
// new input transfer can be taken while the previous result waits on a stalled
// output.

module dual_channel_min_max_mean_tracker_unit
    import mmt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic signed [TEMP_W-1:0]  i_temperature_in,
    input  logic [PRESS_W-1:0]        i_pressure_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accepted,
    output logic signed [TEMP_W-1:0]  o_current_temperature,
    output logic [PRESS_W-1:0]        o_latest_pressure,
    output logic signed [TEMP_W-1:0]  o_min_temperature,
    output logic signed [TEMP_W-1:0]  o_max_temperature,
    output logic signed [TEMP_W-1:0]  o_mean_temperature,
    output logic [PRESS_W-1:0]        o_lowest_pressure,
    output logic [PRESS_W-1:0]        o_highest_pressure,
    output logic [PRESS_W-1:0]        o_mean_pressure
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: accept, update, divide pressure then temperature, hand off result.
    mmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Stores, sums, count, divider and output register.
    mmt_dpath u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_req_type            (i_req_type),
        .i_temperature_in      (i_temperature_in),
        .i_pressure_in         (i_pressure_in),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_accepted            (o_accepted),
        .o_current_temperature (o_current_temperature),
        .o_latest_pressure     (o_latest_pressure),
        .o_min_temperature     (o_min_temperature),
        .o_max_temperature     (o_max_temperature),
        .o_mean_temperature    (o_mean_temperature),
        .o_lowest_pressure     (o_lowest_pressure),
        .o_highest_pressure    (o_highest_pressure),
        .o_mean_pressure       (o_mean_pressure)
    );

endmodule

/* hw/rtl/mmt_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mmt_div
    import mmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [CNT_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [QUO_W-1:0]   o_quotient
);

    logic [CNT_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dsr;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    w_trial;
    logic              w_fit;

    // Quotient is known to fit QUO_W bits, so the top dividend bits start below the divisor.
    assign w_trial = {r_rem, r_dvd[QUO_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUO_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVD_W-1:QUO_W];
            r_dvd <= i_dividend[QUO_W-1:0];
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? CNT_W'(w_trial - {1'b0, r_dsr}) : w_trial[CNT_W-1:0];
            r_dvd <= {r_dvd[QUO_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

/* hw/rtl/mmt_ctrl.sv */
// Controller state machine sequencing update, two mean divisions and result transfer.
`timescale 1ns / 1ps

module mmt_ctrl
    import mmt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_div ? S_PGO : S_OUT;
            end
            S_PGO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_PRESS;
                n_state         = S_PWAIT;
            end
            S_PWAIT: begin
                o_cmd.div_sel = DIV_SEL_PRESS;
                if (i_stat.div_done) begin
                    o_cmd.mean_wr = 1'b1;
                    n_state       = S_TGO;
                end
            end
            S_TGO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_TEMP;
                n_state         = S_TWAIT;
            end
            S_TWAIT: begin
                o_cmd.div_sel = DIV_SEL_TEMP;
                if (i_stat.div_done) begin
                    o_cmd.mean_wr = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* hw/rtl/mmt_dpath.sv */
// Datapath: statistics stores, sums, count, shared divider hookup and output register.
`timescale 1ns / 1ps

module mmt_dpath
    import mmt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    input  logic                      i_req_type,
    input  logic signed [TEMP_W-1:0]  i_temperature_in,
    input  logic [PRESS_W-1:0]        i_pressure_in,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic                      o_accepted,
    output logic signed [TEMP_W-1:0]  o_current_temperature,
    output logic [PRESS_W-1:0]        o_latest_pressure,
    output logic signed [TEMP_W-1:0]  o_min_temperature,
    output logic signed [TEMP_W-1:0]  o_max_temperature,
    output logic signed [TEMP_W-1:0]  o_mean_temperature,
    output logic [PRESS_W-1:0]        o_lowest_pressure,
    output logic [PRESS_W-1:0]        o_highest_pressure,
    output logic [PRESS_W-1:0]        o_mean_pressure
);

    // Captured item
    logic                      r_req;
    logic signed [TEMP_W-1:0]  r_t;
    logic [PRESS_W-1:0]        r_p;

    // Statistics state
    logic signed [TEMP_W-1:0]  r_cur_t, r_min_t, r_max_t, r_mean_t;
    logic [PRESS_W-1:0]        r_cur_p, r_min_p, r_max_p, r_mean_p;
    logic signed [TSUM_W-1:0]  r_tsum;
    logic [PSUM_W-1:0]         r_psum;
    logic [CNT_W-1:0]          r_count;

    // Result flags and output stage
    logic                      r_res_acc;
    logic                      r_res_read;
    logic                      r_out_valid;
    logic                      r_o_acc;
    logic signed [TEMP_W-1:0]  r_o_cur_t, r_o_min_t, r_o_max_t, r_o_mean_t;
    logic [PRESS_W-1:0]        r_o_cur_p, r_o_min_p, r_o_max_p, r_o_mean_p;

    logic                      w_is_read;
    logic                      w_take;
    logic                      w_first;
    logic                      w_below;
    logic [TSUM_W-1:0]         w_tmag;
    logic [DVD_W-1:0]          w_dividend;
    logic                      w_div_done;
    logic [QUO_W-1:0]          w_quo;
    logic [TEMP_W-1:0]         w_tq;

    assign w_is_read = (r_req == REQ_READ);
    assign w_take    = !w_is_read && (r_p != '0);
    assign w_first   = (r_count == '0);
    assign w_below   = (r_count < CNT_W'(MAX_SAMPLES));

    assign w_tmag     = r_tsum[TSUM_W-1] ? (~r_tsum + 1'b1) : r_tsum;
    assign w_dividend = (i_cmd.div_sel == DIV_SEL_TEMP) ? DVD_W'(w_tmag) : DVD_W'(r_psum);
    assign w_tq       = w_quo[TEMP_W-1:0];

    mmt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_req_type;
            r_t   <= i_temperature_in;
            r_p   <= i_pressure_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_t    <= '0;
            r_cur_p    <= '0;
            r_min_t    <= '0;
            r_max_t    <= '0;
            r_min_p    <= '0;
            r_max_p    <= '0;
            r_mean_t   <= '0;
            r_mean_p   <= '0;
            r_tsum     <= '0;
            r_psum     <= '0;
            r_count    <= '0;
            r_res_acc  <= 1'b0;
            r_res_read <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_res_acc  <= w_is_read || w_take;
                r_res_read <= w_is_read;
                if (w_is_read) begin
                    r_count <= '0;
                    r_tsum  <= '0;
                    r_psum  <= '0;
                end else if (w_take) begin
                    r_cur_t <= r_t;
                    r_cur_p <= r_p;
                    if (w_first) begin
                        // First sample after a clear seeds every statistic.
                        r_min_t  <= r_t;
                        r_max_t  <= r_t;
                        r_mean_t <= r_t;
                        r_min_p  <= r_p;
                        r_max_p  <= r_p;
                        r_mean_p <= r_p;
                        r_tsum   <= TSUM_W'(r_t);
                        r_psum   <= PSUM_W'(r_p);
                        r_count  <= CNT_W'(1);
                    end else begin
                        if (r_t < r_min_t) begin
                            r_min_t <= r_t;
                        end else if (r_t > r_max_t) begin
                            r_max_t <= r_t;
                        end
                        if (r_p < r_min_p) begin
                            r_min_p <= r_p;
                        end else if (r_p > r_max_p) begin
                            r_max_p <= r_p;
                        end
                        if (w_below) begin
                            r_count <= r_count + 1'b1;
                            r_tsum  <= r_tsum + TSUM_W'(r_t);
                            r_psum  <= r_psum + PSUM_W'(r_p);
                        end
                    end
                end
            end
            if (i_cmd.mean_wr) begin
                if (i_cmd.div_sel == DIV_SEL_TEMP) begin
                    r_mean_t <= r_tsum[TSUM_W-1] ? -$signed(w_tq) : $signed(w_tq);
                end else begin
                    r_mean_p <= w_quo[PRESS_W-1:0];
                end
            end
        end
    end

    // Output stage: hold the result until the downstream side takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_acc    <= r_res_acc;
            r_o_cur_t  <= r_res_read ? r_cur_t  : '0;
            r_o_cur_p  <= r_res_read ? r_cur_p  : '0;
            r_o_min_t  <= r_res_read ? r_min_t  : '0;
            r_o_max_t  <= r_res_read ? r_max_t  : '0;
            r_o_mean_t <= r_res_read ? r_mean_t : '0;
            r_o_min_p  <= r_res_read ? r_min_p  : '0;
            r_o_max_p  <= r_res_read ? r_max_p  : '0;
            r_o_mean_p <= r_res_read ? r_mean_p : '0;
        end
    end

    assign o_stat.need_div = w_take && !w_first && w_below;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid           = r_out_valid;
    assign o_accepted            = r_o_acc;
    assign o_current_temperature = r_o_cur_t;
    assign o_latest_pressure     = r_o_cur_p;
    assign o_min_temperature     = r_o_min_t;
    assign o_max_temperature     = r_o_max_t;
    assign o_mean_temperature    = r_o_mean_t;
    assign o_lowest_pressure     = r_o_min_p;
    assign o_highest_pressure    = r_o_max_p;
    assign o_mean_pressure       = r_o_mean_p;

endmodule
